// ===== rtl/orientation_to_drive_command_defines.svh =====
// Assertion macros for the orientation to drive command block.
`ifndef ORIENTATION_TO_DRIVE_COMMAND_DEFINES_SVH
`define ORIENTATION_TO_DRIVE_COMMAND_DEFINES_SVH

// Implication checked on every rising edge, quiet during reset.
`define OTD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define OTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/otd_pkg.sv =====
// Shared constants, types and tables for the orientation to drive command block.
package otd_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int QW      = 16;
  localparam int AW      = 32;  // Q16 degree accumulator
  localparam int VW      = 66;  // CORDIC vector width
  localparam int ROLL_W  = 9;
  localparam int PITCH_W = 8;

  localparam logic [1:0] REG_DEAD_BAND = 2'd0;
  localparam logic [1:0] REG_ROLL_LIM  = 2'd1;
  localparam logic [1:0] REG_EDGE_ONE  = 2'd2;
  localparam logic [1:0] REG_EDGE_TWO  = 2'd3;

  localparam logic [2:0] SPEED_PARK = 3'd0;
  localparam logic [2:0] SPEED_FWD1 = 3'd1;
  localparam logic [2:0] SPEED_FWD2 = 3'd2;
  localparam logic [2:0] SPEED_FWD3 = 3'd3;
  localparam logic [2:0] SPEED_REV1 = 3'd4;
  localparam logic [2:0] SPEED_REV2 = 3'd5;
  localparam logic [2:0] SPEED_REV3 = 3'd6;

  typedef struct packed {
    logic [5:0] dead_band;
    logic [6:0] roll_limit;
    logic [6:0] edge_one;
    logic [6:0] edge_two;
  } cfg_t;

  // Vectoring CORDIC lane: vector, Q16 angle, and axis-case override.
  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 fixed;
    logic signed [ROLL_W-1:0] fixed_deg;
  } cordic_t;

  function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:  atan_q16 = 32'sd2949120;
      5'd1:  atan_q16 = 32'sd1740967;
      5'd2:  atan_q16 = 32'sd919879;
      5'd3:  atan_q16 = 32'sd466945;
      5'd4:  atan_q16 = 32'sd234379;
      5'd5:  atan_q16 = 32'sd117304;
      5'd6:  atan_q16 = 32'sd58666;
      5'd7:  atan_q16 = 32'sd29335;
      5'd8:  atan_q16 = 32'sd14668;
      5'd9:  atan_q16 = 32'sd7334;
      5'd10: atan_q16 = 32'sd3667;
      5'd11: atan_q16 = 32'sd1833;
      5'd12: atan_q16 = 32'sd917;
      5'd13: atan_q16 = 32'sd458;
      5'd14: atan_q16 = 32'sd229;
      5'd15: atan_q16 = 32'sd115;
      5'd16: atan_q16 = 32'sd57;
      5'd17: atan_q16 = 32'sd29;
      5'd18: atan_q16 = 32'sd14;
      5'd19: atan_q16 = 32'sd7;
      5'd20: atan_q16 = 32'sd4;
      5'd21: atan_q16 = 32'sd2;
      5'd22: atan_q16 = 32'sd1;
      default: atan_q16 = 32'sd0;
    endcase
  endfunction

endpackage

// ===== rtl/orientation_to_drive_command.sv =====
// Top level: quaternion to roll/pitch, servo angle and speed code.
// Path order: front end, sqrt unit, roll and pitch CORDICs side by side, map stage.
// Throughput: one beat per cycle; busy is always low, start is taken every cycle.
// Roll travels through a delay line to line up with the pitch path.
// Reset (rst, synchronous) clears all valid bits and restores the register defaults.
// The receiver cannot stall: result_valid strobes for exactly one cycle per beat.
`include "orientation_to_drive_command_defines.svh"
module orientation_to_drive_command #(
  parameter int QUAT_FRAC_BITS = otd_pkg::QUAT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES  = otd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [otd_pkg::QW-1:0]      quat_w,
  input  logic signed [otd_pkg::QW-1:0]      quat_x,
  input  logic signed [otd_pkg::QW-1:0]      quat_y,
  input  logic signed [otd_pkg::QW-1:0]      quat_z,
  output logic                               result_valid,
  output logic signed [otd_pkg::ROLL_W-1:0]  roll_degrees,
  output logic signed [otd_pkg::PITCH_W-1:0] pitch_degrees,
  output logic [7:0]                         servo_angle,
  output logic [2:0]                         speed_code,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [7:0]                         cfg_data
);
  import otd_pkg::*;

  localparam int SQ_LAT = 33;  // roll delay line depth, matched to the sqrt unit

  cfg_t cfg;
  logic accept;
  logic fv;
  logic signed [VW-1:0] den, num, s30, c30, s30_d;
  logic sv;
  logic rv, pv;
  logic signed [ROLL_W-1:0] roll_c, pitch_c;
  // roll path delay to match the sqrt unit
  logic signed [VW-1:0] den_d [0:SQ_LAT-1];
  logic signed [VW-1:0] num_d [0:SQ_LAT-1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers; all four indexes are defined
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_band  <= 6'd15;
      cfg.roll_limit <= 7'd60;
      cfg.edge_one   <= 7'd35;
      cfg.edge_two   <= 7'd55;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEAD_BAND: cfg.dead_band  <= cfg_data[5:0];
        REG_ROLL_LIM:  cfg.roll_limit <= cfg_data[6:0];
        REG_EDGE_ONE:  cfg.edge_one   <= cfg_data[6:0];
        REG_EDGE_TWO:  cfg.edge_two   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  otd_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
    .clk(clk), .in_valid(accept), .quat_w(quat_w), .quat_x(quat_x),
    .quat_y(quat_y), .quat_z(quat_z), .out_valid(fv), .den(den), .num(num),
    .s30(s30), .rst(rst)
  );

  otd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(fv), .s30(s30), .out_valid(sv),
    .c30(c30), .s30_out(s30_d)
  );

  always_ff @(posedge clk) begin
    den_d[0] <= den;
    num_d[0] <= num;
    for (int i = 1; i < SQ_LAT; i++) begin
      den_d[i] <= den_d[i-1];
      num_d[i] <= num_d[i-1];
    end
  end

  // both CORDICs see the same valid timing
  otd_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .rst(rst), .in_valid(sv), .x_in(den_d[SQ_LAT-1]),
    .y_in(num_d[SQ_LAT-1]), .out_valid(rv), .deg(roll_c)
  );

  otd_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .rst(rst), .in_valid(sv), .x_in(c30), .y_in(s30_d),
    .out_valid(pv), .deg(pitch_c)
  );

  otd_map u_map (
    .clk(clk), .rst(rst), .in_valid(rv), .cfg(cfg), .roll_in(roll_c),
    .pitch_in(pitch_c), .out_valid(result_valid), .roll_degrees(roll_degrees),
    .pitch_degrees(pitch_degrees), .servo_angle(servo_angle), .speed_code(speed_code)
  );

  `OTD_ASSERT_IMPL(a_paths_aligned, rv || pv, rv == pv, "roll and pitch paths misaligned")
  `OTD_ASSERT_IMPL(a_servo_range, result_valid, servo_angle >= 8'd45 && servo_angle <= 8'd135, "servo out of range")
  `OTD_ASSERT_IMPL(a_speed_range, result_valid, speed_code <= SPEED_REV3, "speed code out of range")
  `OTD_ASSERT_NEXT(a_result_follows, rv, result_valid, "result strobe lost")
endmodule

// ===== rtl/otd_front.sv =====
// Front end: quaternion products, roll vector, clamped pitch sine.
module otd_front #(
  parameter int QUAT_FRAC_BITS = otd_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              in_valid,
  input  logic signed [otd_pkg::QW-1:0]     quat_w,
  input  logic signed [otd_pkg::QW-1:0]     quat_x,
  input  logic signed [otd_pkg::QW-1:0]     quat_y,
  input  logic signed [otd_pkg::QW-1:0]     quat_z,
  output logic                              out_valid,
  output logic signed [otd_pkg::VW-1:0]     den,
  output logic signed [otd_pkg::VW-1:0]     num,
  output logic signed [otd_pkg::VW-1:0]     s30,
  input  logic                              rst
);
  import otd_pkg::*;

  localparam int F2 = 2 * QUAT_FRAC_BITS;

  // stage 1: six products
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx;
  logic               v1;
  // stage 2: sums
  logic signed [VW-1:0] one2;
  logic signed [VW-1:0] s_raw;
  logic               v2;
  logic signed [VW-1:0] s_clamp;

  assign one2 = VW'(1) <<< F2;

  always_ff @(posedge clk) begin
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wy <= quat_w * quat_y;
    p_zx <= quat_z * quat_x;
  end

  always_comb begin
    s_raw = (VW'(p_wy) - VW'(p_zx)) <<< 1;
    if (s_raw > one2)       s_clamp = one2;
    else if (s_raw < -one2) s_clamp = -one2;
    else                    s_clamp = s_raw;
  end

  always_ff @(posedge clk) begin
    num <= (VW'(p_wx) + VW'(p_yz)) <<< 1;
    den <= one2 - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
    if (F2 >= 30) s30 <= s_clamp >>> (F2 - 30);
    else          s30 <= s_clamp <<< (30 - F2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end
  assign out_valid = v2;
endmodule

// ===== rtl/otd_sqrt.sv =====
// Pipelined integer square root of 2^60 - s^2, one root bit per stage.
module otd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [otd_pkg::VW-1:0] s30,
  output logic                          out_valid,
  output logic signed [otd_pkg::VW-1:0] c30,
  output logic signed [otd_pkg::VW-1:0] s30_out
);
  import otd_pkg::*;

  localparam int NS = 31;  // stages for bits 60..0 step 2

  logic [61:0] rem [0:NS];
  logic [61:0] root [0:NS];
  logic signed [VW-1:0] sd [0:NS];
  logic        vld [0:NS];
  logic [30:0] sabs;
  logic [61:0] sq;
  logic signed [VW-1:0] s_d1;
  logic        v_d1;

  // square stage (31x31 bits)
  assign sabs = s30[VW-1] ? 31'(-s30) : 31'(s30);
  always_ff @(posedge clk) begin
    sq   <= sabs * sabs;
    s_d1 <= s30;
  end

  always_ff @(posedge clk) begin
    rem[0]  <= (62'(1) << 60) - sq;
    root[0] <= '0;
    sd[0]   <= s_d1;
  end

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_st
      localparam logic [61:0] B = 62'(1) << (60 - 2 * g);
      always_ff @(posedge clk) begin
        if (rem[g] >= root[g] + B) begin
          rem[g+1]  <= rem[g] - (root[g] + B);
          root[g+1] <= (root[g] >> 1) + B;
        end else begin
          rem[g+1]  <= rem[g];
          root[g+1] <= root[g] >> 1;
        end
        sd[g+1] <= sd[g];
      end
      always_ff @(posedge clk) begin
        if (rst) vld[g+1] <= 1'b0;
        else     vld[g+1] <= vld[g];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d1   <= 1'b0;
      vld[0] <= 1'b0;
    end else begin
      v_d1   <= in_valid;
      vld[0] <= v_d1;
    end
  end

  assign out_valid = vld[NS];
  assign c30       = VW'(root[NS]);
  assign s30_out   = sd[NS];
endmodule

// ===== rtl/otd_cordic.sv =====
// Unrolled vectoring CORDIC: atan2 in whole degrees, truncated toward zero.
module otd_cordic #(
  parameter int CORDIC_STAGES = otd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [otd_pkg::VW-1:0]     x_in,
  input  logic signed [otd_pkg::VW-1:0]     y_in,
  output logic                              out_valid,
  output logic signed [otd_pkg::ROLL_W-1:0] deg
);
  import otd_pkg::*;

  cordic_t st [0:CORDIC_STAGES];
  // vld[k] marks the k-th register stage: fold, CORDIC_STAGES rotations, output
  logic    vld [1:CORDIC_STAGES+2];
  cordic_t pre;
  logic signed [AW-1:0] mag;
  logic signed [AW-1:0] tr;

  // quadrant fold and axis cases
  always_comb begin
    pre           = '0;
    pre.x         = x_in;
    pre.y         = y_in;
    if (y_in == 0) begin
      pre.fixed     = 1'b1;
      pre.fixed_deg = (x_in < 0) ? 9'sd180 : 9'sd0;
    end else if (x_in == 0) begin
      pre.fixed     = 1'b1;
      pre.fixed_deg = (y_in > 0) ? 9'sd90 : -9'sd90;
    end else if (x_in < 0) begin
      if (y_in > 0) begin
        pre.x   = y_in;
        pre.y   = -x_in;
        pre.ang = 32'sd90 <<< 16;
      end else begin
        pre.x   = -y_in;
        pre.y   = x_in;
        pre.ang = -(32'sd90 <<< 16);
      end
    end
  end

  always_ff @(posedge clk) st[0] <= pre;

  genvar g;
  generate
    for (g = 0; g < CORDIC_STAGES; g++) begin : g_st
      localparam int SH = (g < VW) ? g : VW - 1;
      cordic_t nxt;
      always_comb begin
        nxt = st[g];
        if (st[g].y >= 0) begin
          nxt.x   = st[g].x + (st[g].y >>> SH);
          nxt.y   = st[g].y - (st[g].x >>> SH);
          nxt.ang = st[g].ang + atan_q16(5'(g < 32 ? g : 31));
        end else begin
          nxt.x   = st[g].x - (st[g].y >>> SH);
          nxt.y   = st[g].y + (st[g].x >>> SH);
          nxt.ang = st[g].ang - atan_q16(5'(g < 32 ? g : 31));
        end
      end
      always_ff @(posedge clk) st[g+1] <= nxt;
    end
    for (g = 1; g <= CORDIC_STAGES + 2; g++) begin : g_v
      if (g == 1) begin : g_first
        always_ff @(posedge clk) begin
          if (rst) vld[g] <= 1'b0;
          else     vld[g] <= in_valid;
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (rst) vld[g] <= 1'b0;
          else     vld[g] <= vld[g-1];
        end
      end
    end
  endgenerate

  // truncate Q16 toward zero, clamp to +-180
  always_comb begin
    mag = st[CORDIC_STAGES].ang[AW-1] ? -st[CORDIC_STAGES].ang : st[CORDIC_STAGES].ang;
    tr  = st[CORDIC_STAGES].ang[AW-1] ? -(mag >>> 16) : (mag >>> 16);
    if (tr > 180)       tr = 180;
    else if (tr < -180) tr = -180;
  end

  always_ff @(posedge clk) begin
    deg <= st[CORDIC_STAGES].fixed ? st[CORDIC_STAGES].fixed_deg : ROLL_W'(tr);
  end
  assign out_valid = vld[CORDIC_STAGES+2];
endmodule

// ===== rtl/otd_map.sv =====
// Servo angle and speed code mapping from whole-degree roll and pitch.
module otd_map (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  otd_pkg::cfg_t                      cfg,
  input  logic signed [otd_pkg::ROLL_W-1:0]  roll_in,
  input  logic signed [otd_pkg::ROLL_W-1:0]  pitch_in,
  output logic                               out_valid,
  output logic signed [otd_pkg::ROLL_W-1:0]  roll_degrees,
  output logic signed [otd_pkg::PITCH_W-1:0] pitch_degrees,
  output logic [7:0]                         servo_angle,
  output logic [2:0]                         speed_code
);
  import otd_pkg::*;

  logic signed [10:0] r, p, db, lim, e1, e2, sv;
  logic [2:0] spd;

  always_comb begin
    r   = 11'(roll_in);
    p   = 11'(pitch_in);
    if (p > 90)  p = 11'sd90;
    if (p < -90) p = -11'sd90;
    db  = 11'(cfg.dead_band);
    lim = 11'(cfg.roll_limit);
    e1  = 11'(cfg.edge_one);
    e2  = 11'(cfg.edge_two);
    if (r >= -db && r <= db) sv = 11'sd90;
    else if (r < 0)          sv = (r < -lim) ? 11'sd45 : r + 11'sd90 + db;
    else                     sv = (r > lim) ? 11'sd135 : r + 11'sd90 - db;
    if (sv < 45)  sv = 11'sd45;
    if (sv > 135) sv = 11'sd135;
    if (p > -db && p < db)  spd = SPEED_PARK;
    else if (p <= -db)      spd = (p >= -e1) ? SPEED_REV1 : (p >= -e2) ? SPEED_REV2 : SPEED_REV3;
    else                    spd = (p <= e1) ? SPEED_FWD1 : (p <= e2) ? SPEED_FWD2 : SPEED_FWD3;
  end

  always_ff @(posedge clk) begin
    roll_degrees  <= roll_in;
    pitch_degrees <= PITCH_W'(p);
    servo_angle   <= 8'(sv);
    speed_code    <= spd;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end
endmodule

// ===== verif/tb_orientation_to_drive_command.sv =====
// Testbench for orientation_to_drive_command: random and directed quaternions, scoreboarded.
`timescale 1ns / 1ps
module tb_orientation_to_drive_command;
  import otd_pkg::*;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct {
    logic signed [8:0] roll;
    logic signed [7:0] pitch;
    logic [7:0]        servo;
    logic [2:0]        speed;
  } drive_cmd_t;

  // atan(2^-i) in Q16 degrees, one entry per CORDIC stage
  localparam longint ATAN_Q16 [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
  localparam int FLUSH_CYCLES = 80;  // drain slack, longer than the block latency at default sizes

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = REG_DEAD_BAND;
  logic [7:0] cfg_data = '0;
  logic busy, result_valid, cfg_ready;
  logic signed [8:0] roll_degrees;
  logic signed [7:0] pitch_degrees;
  logic [7:0] servo_angle;
  logic [2:0] speed_code;

  orientation_to_drive_command u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .result_valid(result_valid), .roll_degrees(roll_degrees),
    .pitch_degrees(pitch_degrees), .servo_angle(servo_angle), .speed_code(speed_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #2 clk = ~clk;

  // Shadow copy of the block's registers.
  int unsigned dead_band = 15, roll_limit = 60, edge_one = 35, edge_two = 55;

  quat_t      pending_quats[$];
  drive_cmd_t expected_cmds[$];
  int         errors = 0;
  logic       took = 1'b0;  // start beat accepted at the last rising edge

  // Vectoring CORDIC, angle of (x, y) in whole degrees truncated toward zero.
  function automatic longint cordic_deg(longint vx, longint vy);
    longint ang, t, nx, ny, a;
    ang = 0;
    if (vy == 0) return (vx < 0) ? 180 : 0;
    if (vx == 0) return (vy > 0) ? 90 : -90;
    // left half plane: pre-rotate by a quarter turn
    if (vx < 0) begin
      if (vy > 0) begin
        t = vx; vx = vy; vy = -t; ang = 90 <<< 16;
      end else begin
        t = vx; vx = -vy; vy = t; ang = -(90 <<< 16);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (vy >= 0) begin
        nx = vx + (vy >>> i); ny = vy - (vx >>> i); ang += ATAN_Q16[i];
      end else begin
        nx = vx - (vy >>> i); ny = vy + (vx >>> i); ang -= ATAN_Q16[i];
      end
      vx = nx; vy = ny;
    end
    a = (ang < 0) ? -((-ang) >>> 16) : (ang >>> 16);
    if (a > 180) a = 180;
    if (a < -180) a = -180;
    return a;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic drive_cmd_t drive_cmd_of(quat_t q);
    drive_cmd_t c;
    longint w, x, y, z, one2, num, den, s, cs, roll, pitch, servo, db, lim, e1, e2;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one2 = 64'sd1 <<< 30;
    db = dead_band; lim = roll_limit; e1 = edge_one; e2 = edge_two;
    num = 2 * (w * x + y * z);
    den = one2 - 2 * (x * x + y * y);
    roll = cordic_deg(den, num);
    // asin via atan2(s, sqrt(1 - s^2)); Q30 already at 15 fraction bits
    s = 2 * (w * y - z * x);
    if (s > one2) s = one2;
    if (s < -one2) s = -one2;
    cs = longint'(int_sqrt((64'd1 << 60) - longint'(s * s)));
    pitch = cordic_deg(cs, s);
    if (pitch > 90) pitch = 90;
    if (pitch < -90) pitch = -90;
    // boundary roll = +-dead band stays straight
    if (roll >= -db && roll <= db) servo = 90;
    else if (roll < 0) servo = (roll < -lim) ? 45 : roll + 90 + db;
    else servo = (roll > lim) ? 135 : roll + 90 - db;
    if (servo < 45) servo = 45;
    if (servo > 135) servo = 135;
    if (pitch > -db && pitch < db) c.speed = SPEED_PARK;
    else if (pitch <= -db)
      c.speed = (pitch >= -e1) ? SPEED_REV1 : (pitch >= -e2) ? SPEED_REV2 : SPEED_REV3;
    else
      c.speed = (pitch <= e1) ? SPEED_FWD1 : (pitch <= e2) ? SPEED_FWD2 : SPEED_FWD3;
    c.roll = roll[8:0];
    c.pitch = pitch[7:0];
    c.servo = servo[7:0];
    return c;
  endfunction

  // Driver: one input beat per item, random gaps with bursts of back-to-back beats.
  int  gap = 0;
  bit  burst = 1'b0;
  always @(negedge clk) begin
    quat_t q;
    if (!rst && !(start && !took)) begin
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        q = pending_quats.pop_front();
        quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
        start <= 1'b1;
        if ($urandom_range(0, 30) == 0) burst = ~burst;
        gap = burst ? 0 : $urandom_range(0, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on every accepted beat, check every result strobe.
  always @(posedge clk) begin
    drive_cmd_t e;
    quat_t q;
    took <= start && !busy;
    if (!rst && start && !busy) begin
      q.w = quat_w; q.x = quat_x; q.y = quat_y; q.z = quat_z;
      expected_cmds.push_back(drive_cmd_of(q));
    end
    if (!rst && result_valid) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: result with nothing expected: roll %0d pitch %0d servo %0d speed %0d",
                 $time, roll_degrees, pitch_degrees, servo_angle, speed_code);
        errors++;
      end else begin
        e = expected_cmds.pop_front();
        if (roll_degrees !== e.roll) begin
          $display("%0t: roll exp %0d got %0d", $time, e.roll, roll_degrees); errors++;
        end
        if (pitch_degrees !== e.pitch) begin
          $display("%0t: pitch exp %0d got %0d", $time, e.pitch, pitch_degrees); errors++;
        end
        if (servo_angle !== e.servo) begin
          $display("%0t: servo exp %0d got %0d", $time, e.servo, servo_angle); errors++;
        end
        if (speed_code !== e.speed) begin
          $display("%0t: speed exp %0d got %0d", $time, e.speed, speed_code); errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEAD_BAND: dead_band = data[5:0];
      REG_ROLL_LIM:  roll_limit = data[6:0];
      REG_EDGE_ONE:  edge_one = data[6:0];
      default:       edge_two = data[6:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int db, int lim, int e1, int e2);
    write_reg(REG_DEAD_BAND, db[7:0]);
    write_reg(REG_ROLL_LIM, lim[7:0]);
    write_reg(REG_EDGE_ONE, e1[7:0]);
    write_reg(REG_EDGE_TWO, e2[7:0]);
  endtask

  task automatic push_raw(int w, int x, int y, int z);
    quat_t q;
    q.w = w[15:0]; q.x = x[15:0]; q.y = y[15:0]; q.z = z[15:0];
    pending_quats.push_back(q);
  endtask

  // Unit quaternion from roll/pitch/yaw in degrees.
  task automatic push_euler(real r, real p, real yw);
    real cr, sr, cp, sp, cy, sy, k;
    k = 3.14159265358979 / 360.0;  // half angle in radians
    cr = $cos(r * k); sr = $sin(r * k);
    cp = $cos(p * k); sp = $sin(p * k);
    cy = $cos(yw * k); sy = $sin(yw * k);
    push_raw($rtoi(32767.0 * (cr * cp * cy + sr * sp * sy)),
             $rtoi(32767.0 * (sr * cp * cy - cr * sp * sy)),
             $rtoi(32767.0 * (cr * sp * cy + sr * cp * sy)),
             $rtoi(32767.0 * (cr * cp * sy - sr * sp * cy)));
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7)
        push_euler($itor($urandom_range(0, 3600)) / 10.0 - 180.0,
                   $itor($urandom_range(0, 1800)) / 10.0 - 90.0,
                   $itor($urandom_range(0, 3600)) / 10.0 - 180.0);
      else
        push_raw($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Pipeline fully empty: nothing queued, nothing in flight, then latency slack.
  task automatic drain();
    do @(posedge clk); while (pending_quats.size() > 0 || start || expected_cmds.size() > 0);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass at reset register values.
    push_raw(32767, 0, 0, 0);             // level
    push_raw(0, 0, 0, 0);                 // zero vector
    push_raw(-32768, -32768, -32768, -32768);
    push_raw(32767, 32767, 32767, 32767); // far out of unit length
    push_raw(0, 32767, 0, 0);             // roll 180 axis
    push_raw(23170, 23170, 0, 0);         // roll +90
    push_raw(23170, -23170, 0, 0);        // roll -90
    push_raw(23170, 0, 23170, 0);         // pitch +90
    push_raw(23170, 0, -23170, 0);        // pitch -90
    push_raw(32767, -32768, 32767, -32768);
    for (int a = -60; a <= 60; a += 15) push_euler(a, 0.0, 0.0);   // servo edges
    push_euler(0.0, 15.0, 0.0); push_euler(0.0, -15.0, 0.0);
    push_euler(0.0, 40.0, 0.0); push_euler(0.0, -60.0, 0.0);
    drain();

    // Extremes, defaults and random register settings, each with random traffic.
    set_regs(0, 0, 0, 0);     push_random(90); drain();
    set_regs(45, 90, 90, 90); push_random(90); drain();
    set_regs(63, 127, 127, 127); push_random(60); drain();
    set_regs(15, 60, 35, 55); push_random(90); drain();
    for (int p = 0; p < 2; p++) begin
      set_regs($urandom_range(0, 45), $urandom_range(0, 90),
               $urandom_range(0, 90), $urandom_range(0, 90));
      push_random(60);
      drain();
    end
    write_reg(REG_DEAD_BAND, 8'($urandom)); write_reg(REG_ROLL_LIM, 8'($urandom));
    write_reg(REG_EDGE_ONE, 8'($urandom));  write_reg(REG_EDGE_TWO, 8'($urandom));
    push_random(60);
    drain();

    if (errors == 0)
      $display("tb_orientation_to_drive_command: done, clean");
    else
      $display("tb_orientation_to_drive_command: done, errors");
    $finish;
  end

  initial begin
    #400000;
    $display("tb_orientation_to_drive_command: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/otd_pkg.sv
rtl/otd_front.sv
rtl/otd_sqrt.sv
rtl/otd_cordic.sv
rtl/otd_map.sv
rtl/orientation_to_drive_command.sv
verif/tb_orientation_to_drive_command.sv
